/* design/rlpe_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlpe_pkg
// Shared types and constants for the run-level parity embedder.
// ----------------------------------------------------------------------------
package rlpe_pkg;

   localparam int RUN_BITS    = 4;
   localparam int LIMIT_BITS  = 16;
   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 16'd10;

   // Values above this step down, all others step up
   localparam int PARITY_PIVOT = 128;

   // Per-block decision passed from the front to the back
   typedef struct packed {
      logic bank;   // pair store bank holding the block
      logic used;   // secret bit consumed
      logic chg;    // last nonzero coefficient modified
   } ctl_type;

   localparam int CTL_BITS = $bits(ctl_type);

endpackage

/* design/run_level_parity_embed.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// run_level_parity_embed
// Hides up to one secret bit per block in the parity of the last nonzero
// coefficient of a block of run-level pairs.
// ----------------------------------------------------------------------------
//  port group | direction | moves
//  req_*      | in        | one (level, run, secret bit) pair per request
//  rsp_*      | out       | one emitted pair per request, BLOCK_SIZE per block
//  csr_*      | in        | embed_limit write, no wait
//
//  Requests are taken one per cycle while the decision queue has room.
//  The pair store has two banks, so one block loads while the previous
//  one drains; BLOCK_SIZE results leave at one per cycle, and a block is
//  read only after the one before has left the queue. Either side may
//  stall freely. Reset clears counters, flags and the queue and sets
//  embed_limit to 10; there is no clearing pass.
// ----------------------------------------------------------------------------
module run_level_parity_embed import rlpe_pkg::*; #(
   parameter int BLOCK_SIZE = 16,
   parameter int LEVEL_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [LIMIT_BITS-1:0] csr_wr_data,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [LEVEL_BITS-1:0] req_level,
   input  logic [RUN_BITS-1:0]   req_run,
   input  logic                  req_secret_bit,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [LEVEL_BITS-1:0] rsp_out_level,
   output logic [RUN_BITS-1:0]   rsp_out_run,
   output logic                  rsp_last_pair,
   output logic                  rsp_bit_used,
   output logic                  rsp_changed
);

   localparam int IDX_W  = $clog2(BLOCK_SIZE);
   localparam int Q_W    = CTL_BITS + IDX_W + LEVEL_BITS;
   localparam int PAIR_W = LEVEL_BITS + RUN_BITS;

   logic              ram_wr_en;
   logic [IDX_W:0]    ram_wr_addr;
   logic [PAIR_W-1:0] ram_wr_data;
   logic              ram_rd_en;
   logic [IDX_W:0]    ram_rd_addr;
   logic [PAIR_W-1:0] ram_rd_data;
   logic              q_push;
   logic [Q_W-1:0]    q_push_data;
   logic              q_full;
   logic              q_valid;
   logic [Q_W-1:0]    q_head;
   logic              q_pop;

   rlpe_front #(
      .BLOCK_SIZE (BLOCK_SIZE),
      .LEVEL_BITS (LEVEL_BITS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_level      (req_level),
      .req_run        (req_run),
      .req_secret_bit (req_secret_bit),
      .ram_wr_en      (ram_wr_en),
      .ram_wr_addr    (ram_wr_addr),
      .ram_wr_data    (ram_wr_data),
      .q_push         (q_push),
      .q_data         (q_push_data),
      .q_full         (q_full)
   );

   // bank bit on top of the pair index, so the depth is a full power of two
   rlpe_ram #(
      .WIDTH (PAIR_W),
      .DEPTH (2 ** (IDX_W + 1))
   ) u_pair_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   rlpe_queue #(
      .WIDTH (Q_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (q_push_data),
      .full       (q_full),
      .head_valid (q_valid),
      .head_data  (q_head),
      .pop        (q_pop)
   );

   rlpe_back #(
      .BLOCK_SIZE (BLOCK_SIZE),
      .LEVEL_BITS (LEVEL_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_valid),
      .q_data        (q_head),
      .q_pop         (q_pop),
      .ram_rd_en     (ram_rd_en),
      .ram_rd_addr   (ram_rd_addr),
      .ram_rd_data   (ram_rd_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_level (rsp_out_level),
      .rsp_out_run   (rsp_out_run),
      .rsp_last_pair (rsp_last_pair),
      .rsp_bit_used  (rsp_bit_used),
      .rsp_changed   (rsp_changed)
   );

endmodule

/* design/rlpe_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlpe_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module rlpe_ram #(
   parameter int WIDTH = 20,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/rlpe_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlpe_queue
// Two-entry queue of block decisions between the front and the back.
// ----------------------------------------------------------------------------
module rlpe_queue #(
   parameter int WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   output logic             head_valid,
   output logic [WIDTH-1:0] head_data,
   input  logic             pop
);

   logic [WIDTH-1:0] slot_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       cnt_ff, cnt_in;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign full       = cnt_ff[1];
   assign head_valid = cnt_ff != 2'd0;
   assign head_data  = slot_ff[rd_ptr_ff];

endmodule

/* design/rlpe_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlpe_front
// Accepts pairs, stores them and tracks the scan position of each one, so
// that the last nonzero coefficient is known when the block completes.
// ----------------------------------------------------------------------------
module rlpe_front import rlpe_pkg::*; #(
   parameter int BLOCK_SIZE = 16,
   parameter int LEVEL_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [LIMIT_BITS-1:0]              csr_wr_data,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [LEVEL_BITS-1:0]              req_level,
   input  logic [RUN_BITS-1:0]                req_run,
   input  logic                               req_secret_bit,
   output logic                               ram_wr_en,
   output logic [$clog2(BLOCK_SIZE):0]        ram_wr_addr,
   output logic [LEVEL_BITS+RUN_BITS-1:0]     ram_wr_data,
   output logic                               q_push,
   output logic [CTL_BITS+$clog2(BLOCK_SIZE)+LEVEL_BITS-1:0] q_data,
   input  logic                               q_full
);

   localparam int IDX_W = $clog2(BLOCK_SIZE);
   localparam int POS_W = $clog2(BLOCK_SIZE + 16);
   localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = {1'b0, {(LEVEL_BITS-1){1'b1}}};

   logic [IDX_W-1:0]      pair_cnt_ff, pair_cnt_in;
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic                  done_ff, done_in;
   logic                  any_ff, any_in;
   logic [IDX_W-1:0]      last_idx_ff, last_idx_in;
   logic [LEVEL_BITS-1:0] last_val_ff, last_val_in;
   logic                  bank_ff, bank_in;
   logic [LIMIT_BITS-1:0] bits_ff, bits_in;
   logic [LIMIT_BITS-1:0] limit_ff, limit_in;

   logic                  accept;
   logic                  level_nz;
   logic [POS_W-1:0]      pos_sum;
   logic [POS_W-1:0]      pos_nxt;
   logic                  in_range;
   logic                  writes;
   logic                  blk_end;
   logic                  eff_any;
   logic [IDX_W-1:0]      eff_idx;
   logic [LEVEL_BITS-1:0] eff_val;
   logic                  step_down;
   logic [LEVEL_BITS-1:0] new_val;
   ctl_type               ctl;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   // scan position of this pair; anything at or past the end is dropped
   assign level_nz = req_level != '0;
   assign pos_sum  = pos_ff + POS_W'(req_run);
   assign pos_nxt  = pos_sum + POS_W'(1);
   assign in_range = pos_sum < POS_W'(BLOCK_SIZE);
   assign writes   = !done_ff && level_nz && in_range;
   assign blk_end  = pair_cnt_ff == IDX_W'(BLOCK_SIZE - 1);

   // positions rise strictly, so the last placed pair is the last nonzero
   assign eff_any = any_ff || writes;
   assign eff_idx = writes ? pair_cnt_ff : last_idx_ff;
   assign eff_val = writes ? req_level : last_val_ff;

   assign step_down = ($signed({eff_val[LEVEL_BITS-1], eff_val}) >
                       $signed((LEVEL_BITS+1)'(PARITY_PIVOT))) ||
                      (eff_val == LEVEL_MAX);
   assign new_val   = step_down ? eff_val - LEVEL_BITS'(1) : eff_val + LEVEL_BITS'(1);

   always_comb begin
      ctl.bank = bank_ff;
      ctl.used = eff_any && (bits_ff < limit_ff);
      ctl.chg  = ctl.used && (req_secret_bit ^ eff_val[0]);
   end

   assign q_push      = accept && blk_end;
   assign q_data      = {ctl, eff_idx, new_val};
   assign ram_wr_en   = accept;
   assign ram_wr_addr = {bank_ff, pair_cnt_ff};
   assign ram_wr_data = {req_level, req_run};

   always_comb begin
      pair_cnt_in = pair_cnt_ff;
      pos_in      = pos_ff;
      done_in     = done_ff;
      any_in      = any_ff;
      last_idx_in = last_idx_ff;
      last_val_in = last_val_ff;
      bank_in     = bank_ff;
      bits_in     = bits_ff;
      limit_in    = csr_wr_en ? csr_wr_data : limit_ff;
      if (accept) begin
         if (blk_end) begin
            pair_cnt_in = '0;
            pos_in      = '0;
            done_in     = 1'b0;
            any_in      = 1'b0;
            bank_in     = ~bank_ff;
            bits_in     = bits_ff + LIMIT_BITS'(ctl.used);
         end else begin
            pair_cnt_in = pair_cnt_ff + IDX_W'(1);
            if (writes) begin
               pos_in      = pos_nxt;
               any_in      = 1'b1;
               last_idx_in = pair_cnt_ff;
               last_val_in = req_level;
            end
            done_in = done_ff || !level_nz || !in_range ||
                      (writes && (pos_nxt >= POS_W'(BLOCK_SIZE)));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pair_cnt_ff <= '0;
         pos_ff      <= '0;
         done_ff     <= 1'b0;
         any_ff      <= 1'b0;
         bank_ff     <= 1'b0;
         bits_ff     <= '0;
         limit_ff    <= LIMIT_RESET;
      end else begin
         pair_cnt_ff <= pair_cnt_in;
         pos_ff      <= pos_in;
         done_ff     <= done_in;
         any_ff      <= any_in;
         bank_ff     <= bank_in;
         bits_ff     <= bits_in;
         limit_ff    <= limit_in;
      end
   end

   always_ff @(posedge clock) begin
      last_idx_ff <= last_idx_in;
      last_val_ff <= last_val_in;
   end

endmodule

/* design/rlpe_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlpe_back
// Reads a finished block back from the pair store and emits its pairs,
// patching the changed coefficient and zero padding where needed.
// ----------------------------------------------------------------------------
module rlpe_back import rlpe_pkg::*; #(
   parameter int BLOCK_SIZE = 16,
   parameter int LEVEL_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               q_valid,
   input  logic [CTL_BITS+$clog2(BLOCK_SIZE)+LEVEL_BITS-1:0] q_data,
   output logic                               q_pop,
   output logic                               ram_rd_en,
   output logic [$clog2(BLOCK_SIZE):0]        ram_rd_addr,
   input  logic [LEVEL_BITS+RUN_BITS-1:0]     ram_rd_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [LEVEL_BITS-1:0]              rsp_out_level,
   output logic [RUN_BITS-1:0]                rsp_out_run,
   output logic                               rsp_last_pair,
   output logic                               rsp_bit_used,
   output logic                               rsp_changed
);

   localparam int IDX_W = $clog2(BLOCK_SIZE);
   localparam int Q_W   = CTL_BITS + IDX_W + LEVEL_BITS;

   ctl_type               head_ctl;
   logic [IDX_W-1:0]      head_idx;
   logic [LEVEL_BITS-1:0] head_val;

   logic [IDX_W:0]        iss_cnt_ff, iss_cnt_in;
   logic                  s1_valid_ff, s1_valid_in;
   logic [IDX_W-1:0]      s1_idx_ff, s1_idx_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_BITS-1:0] level_ff, level_in;
   logic [RUN_BITS-1:0]   run_ff, run_in;
   logic                  last_ff, last_in;
   logic                  used_ff, used_in;
   logic                  chg_ff, chg_in;

   logic                  s2_take;
   logic                  s1_move;
   logic                  issue;
   logic [LEVEL_BITS-1:0] rd_level;
   logic [RUN_BITS-1:0]   rd_run;

   assign head_ctl = ctl_type'(q_data[Q_W-1 -: CTL_BITS]);
   assign head_idx = q_data[LEVEL_BITS +: IDX_W];
   assign head_val = q_data[LEVEL_BITS-1:0];
   assign rd_level = ram_rd_data[LEVEL_BITS+RUN_BITS-1 -: LEVEL_BITS];
   assign rd_run   = ram_rd_data[RUN_BITS-1:0];

   assign s2_take = !rsp_valid_ff || rsp_ready;
   assign s1_move = s1_valid_ff && s2_take;
   assign issue   = q_valid && (iss_cnt_ff < (IDX_W+1)'(BLOCK_SIZE)) &&
                    (!s1_valid_ff || s1_move);
   // the decision leaves the queue only once its final pair has been read
   assign q_pop   = s1_move && (s1_idx_ff == IDX_W'(BLOCK_SIZE - 1));

   assign ram_rd_en   = issue;
   assign ram_rd_addr = {head_ctl.bank, iss_cnt_ff[IDX_W-1:0]};

   always_comb begin
      iss_cnt_in = iss_cnt_ff;
      if (q_pop) begin
         iss_cnt_in = '0;
      end else if (issue) begin
         iss_cnt_in = iss_cnt_ff + (IDX_W+1)'(1);
      end
      s1_valid_in = issue ? 1'b1 : (s1_move ? 1'b0 : s1_valid_ff);
      s1_idx_in   = issue ? iss_cnt_ff[IDX_W-1:0] : s1_idx_ff;
   end

   always_comb begin
      rsp_valid_in = s1_move ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
      level_in     = level_ff;
      run_in       = run_ff;
      last_in      = last_ff;
      used_in      = used_ff;
      chg_in       = chg_ff;
      if (s1_move) begin
         level_in = rd_level;
         run_in   = rd_run;
         if (head_ctl.chg) begin
            if (s1_idx_ff == head_idx) begin
               // a coefficient that stepped to zero drops out of the list
               level_in = head_val;
               run_in   = (head_val == '0) ? '0 : rd_run;
            end else if (s1_idx_ff > head_idx) begin
               level_in = '0;
               run_in   = '0;
            end
         end
         last_in = s1_idx_ff == IDX_W'(BLOCK_SIZE - 1);
         used_in = head_ctl.used;
         chg_in  = head_ctl.chg;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         iss_cnt_ff   <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         iss_cnt_ff   <= iss_cnt_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_idx_ff <= s1_idx_in;
      level_ff  <= level_in;
      run_ff    <= run_in;
      last_ff   <= last_in;
      used_ff   <= used_in;
      chg_ff    <= chg_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_level = level_ff;
   assign rsp_out_run   = run_ff;
   assign rsp_last_pair = last_ff;
   assign rsp_bit_used  = used_ff;
   assign rsp_changed   = chg_ff;

endmodule
